// ----- sv/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, types and helpers for the page replacement cell row.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int FRAMES     = 16;
   localparam int SLOT_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W      = $clog2(FRAMES + 1);
   localparam int PAGE_W     = 8;
   localparam int STAMP_W    = 32;
   localparam int TOTAL_W    = 32;
   localparam int CFG_W      = 5;
   localparam int SLOT_OUT_W = 4;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [CFG_W-1:0]   cfg_type;

   // Search word that walks down the cell row, one cell per cycle
   typedef struct packed {
      logic      active;
      page_type  page;
      logic      hit;
      slot_type  hit_slot;
      logic      have_old;
      stamp_type old_stamp;
      slot_type  old_slot;
      page_type  old_page;
   } probe_type;

   // Control fanned out from the controller to every cell
   typedef struct packed {
      cnt_type   filled;
      cnt_type   limit;
      logic      wr_en;
      slot_type  wr_slot;
      page_type  wr_page;
      stamp_type wr_stamp;
   } bcast_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   // Clamp the frame count register to 1..FRAMES
   function automatic cnt_type frames_limit(input cfg_type count);
      logic [31:0] n;
      n = 32'(count);
      if (n == 32'd0) begin
         n = 32'd1;
      end
      if (n > 32'(FRAMES)) begin
         n = 32'(FRAMES);
      end
      return n[CNT_W-1:0];
   endfunction

endpackage

// ----- sv/lrupr_ifs.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement channels
// Valid/ready channels for references, results and the frame count register.
// ----------------------------------------------------------------------------
interface lrupr_req_if import lrupr_pkg::*; ();
   logic     valid;
   logic     ready;
   page_type page;
   logic     end_of_string;

   modport source (output valid, output page, output end_of_string, input ready);
   modport sink   (input valid, input page, input end_of_string, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  fault;
   logic [SLOT_OUT_W-1:0] frame_slot;
   logic                  evicted;
   page_type              victim_page;
   total_type             fault_total;

   modport source (output valid, output fault, output frame_slot, output evicted,
                   output victim_page, output fault_total, input ready);
   modport sink   (input valid, input fault, input frame_slot, input evicted,
                   input victim_page, input fault_total, output ready);
endinterface

interface lrupr_csr_if import lrupr_pkg::*; ();
   logic    valid;
   logic    ready;
   cfg_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/lru_page_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative least-recently-used frame replacement over a cell row.
// ----------------------------------------------------------------------------
// One reference is handled at a time. An accepted page is launched as a search
// word down a row of FRAMES frame cells, one cell per cycle; each cell checks
// for a hit and tracks the oldest replacement candidate (lowest index wins a
// tie). When the word leaves the last cell the controller commits the hit,
// fill or eviction and registers the result. A result still waiting on rsp
// holds the next result in the controller, and no new reference is taken
// until the waiting word leaves. The frame count register is written through
// csr; write it only while no reference is in flight.
module lru_page_replacement_unit import lrupr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   lrupr_req_if.sink    req_chan,
   lrupr_rsp_if.source  rsp_chan,
   lrupr_csr_if.sink    csr_chan
);

   bcast_type bcast;
   probe_type probe_inj;
   probe_type probe_chain [FRAMES];

   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .bcast      (bcast),
      .probe_inj  (probe_inj),
      .probe_done (probe_chain[FRAMES-1])
   );

   // Row of frame cells, each feeding the next
   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      if (i == 0) begin : g_head
         lrupr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_idx   (slot_type'(i)),
            .bcast      (bcast),
            .probe_prev (probe_inj),
            .probe_next (probe_chain[i])
         );
      end else begin : g_body
         lrupr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_idx   (slot_type'(i)),
            .bcast      (bcast),
            .probe_prev (probe_chain[i-1]),
            .probe_next (probe_chain[i])
         );
      end
   end

endmodule

// ----- sv/lrupr_cell.sv -----
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame's page and last-use stamp; folds itself into the passing
// search word (first hit, oldest candidate) and hands it to the next cell.
// ----------------------------------------------------------------------------
module lrupr_cell import lrupr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  slot_type  cell_idx,
   input  bcast_type bcast,
   input  probe_type probe_prev,
   output probe_type probe_next
);

   page_type  page_ff;
   stamp_type stamp_ff;
   probe_type probe_ff;
   probe_type probe_in;
   logic      is_filled;
   logic      is_cand;
   logic      match;
   logic      older;

   // Fold this frame into the search word
   always_comb begin
      probe_in  = probe_prev;
      is_filled = cnt_type'(cell_idx) < bcast.filled;
      is_cand   = cnt_type'(cell_idx) < bcast.limit;
      match     = probe_prev.active && is_filled && !probe_prev.hit &&
                  (page_ff == probe_prev.page);
      older     = probe_prev.active && is_cand &&
                  (!probe_prev.have_old || (stamp_ff < probe_prev.old_stamp));
      if (match) begin
         probe_in.hit      = 1'b1;
         probe_in.hit_slot = cell_idx;
      end
      if (older) begin
         probe_in.have_old  = 1'b1;
         probe_in.old_stamp = stamp_ff;
         probe_in.old_slot  = cell_idx;
         probe_in.old_page  = page_ff;
      end
   end

   // Advance the search word one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   // Write the frame when the controller selects this slot
   always_ff @(posedge clock) begin
      if (bcast.wr_en && (bcast.wr_slot == cell_idx)) begin
         page_ff  <= bcast.wr_page;
         stamp_ff <= bcast.wr_stamp;
      end
   end

   assign probe_next = probe_ff;

endmodule

// ----- sv/lrupr_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU replacement controller
// Takes references, launches search words into the cell row, decides hit,
// fill or eviction, updates counters and registers the result word.
// ----------------------------------------------------------------------------
module lrupr_ctrl import lrupr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   lrupr_req_if.sink          req_chan,
   lrupr_rsp_if.source        rsp_chan,
   lrupr_csr_if.sink          csr_chan,
   output bcast_type          bcast,
   output probe_type          probe_inj,
   input  probe_type          probe_done
);

   state_type state_ff, state_in;
   cfg_type   frame_count_ff;
   cnt_type   filled_ff, filled_in;
   stamp_type clock_ff;
   total_type faults_ff, faults_in;
   cnt_type   limit_ff;
   logic      eos_ff;
   probe_type inj_ff, inj_in;

   logic      res_fault_ff, res_evicted_ff;
   slot_type  res_slot_ff;
   page_type  res_victim_ff;
   total_type res_total_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_fault_ff, rsp_evicted_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   page_type              rsp_victim_ff;
   total_type             rsp_total_ff;

   logic        accept;
   logic        commit;
   logic        has_free;
   logic        fault;
   logic        evict;
   slot_type    slot;
   page_type    victim;
   logic        load;
   logic [31:0] slot_wide;

   assign accept = req_chan.valid && req_chan.ready && (state_ff == ST_IDLE);
   assign commit = (state_ff == ST_SCAN) && probe_done.active;
   assign load   = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_chan.ready);

   // Decide hit, fill or eviction from the returning search word
   always_comb begin
      has_free  = filled_ff < limit_ff;
      fault     = !probe_done.hit;
      evict     = fault && !has_free;
      victim    = evict ? probe_done.old_page : '0;
      filled_in = filled_ff;
      faults_in = faults_ff;
      if (probe_done.hit) begin
         slot = probe_done.hit_slot;
      end else if (has_free) begin
         slot      = filled_ff[SLOT_W-1:0];
         filled_in = filled_ff + cnt_type'(1);
      end else begin
         slot = probe_done.old_slot;
      end
      if (fault && (faults_ff != '1)) begin
         faults_in = faults_ff + total_type'(1);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (commit) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Launch word for cell zero
   always_comb begin
      inj_in        = '0;
      inj_in.active = accept;
      inj_in.page   = req_chan.page;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= cfg_type'(4);
         filled_ff      <= '0;
         clock_ff       <= '0;
         faults_ff      <= '0;
         inj_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         inj_ff   <= inj_in;
         if (csr_chan.valid && csr_chan.ready) begin
            frame_count_ff <= csr_chan.data;
         end
         if (accept && (clock_ff != '1)) begin
            clock_ff <= clock_ff + stamp_type'(1);
         end
         if (commit) begin
            if (eos_ff) begin
               filled_ff <= '0;
               clock_ff  <= '0;
               faults_ff <= '0;
            end else begin
               filled_ff <= filled_in;
               faults_ff <= faults_in;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Latch reference attributes on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         limit_ff <= frames_limit(frame_count_ff);
         eos_ff   <= req_chan.end_of_string;
      end
   end

   // Hold the result until the output register frees up
   always_ff @(posedge clock) begin
      if (commit) begin
         res_fault_ff   <= fault;
         res_slot_ff    <= slot;
         res_evicted_ff <= evict;
         res_victim_ff  <= victim;
         res_total_ff   <= faults_in;
      end
   end

   assign slot_wide = 32'(res_slot_ff);

   // Output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_fault_ff   <= res_fault_ff;
         rsp_slot_ff    <= slot_wide[SLOT_OUT_W-1:0];
         rsp_evicted_ff <= res_evicted_ff;
         rsp_victim_ff  <= res_victim_ff;
         rsp_total_ff   <= res_total_ff;
      end
   end

   // Broadcast to the cell row
   always_comb begin
      bcast.filled   = filled_ff;
      bcast.limit    = limit_ff;
      bcast.wr_en    = commit;
      bcast.wr_slot  = slot;
      bcast.wr_page  = probe_done.page;
      bcast.wr_stamp = clock_ff;
   end

   assign probe_inj            = inj_ff;
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fault       = rsp_fault_ff;
   assign rsp_chan.frame_slot  = rsp_slot_ff;
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.victim_page = rsp_victim_ff;
   assign rsp_chan.fault_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= cnt_type'(FRAMES))
      else $error("filled frame count exceeds frame row");

   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      probe_done.active |-> (state_ff == ST_SCAN))
      else $error("search word returned outside scan");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && probe_inj.active)
      else $error("accepted reference did not launch a search");

   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && !probe_done.active) |=>
         ($stable(filled_ff) && $stable(faults_ff)))
      else $error("counters moved during scan");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("result load did not raise valid");
`endif

endmodule
